@@ design/ksft_pkg.sv @@
`timescale 1ns / 1ps

package ksft_pkg;

  // Key FIFO geometry.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Set-1 make codes of the keys that the translator handles itself.
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_NUM    = 7'h45;
  localparam logic [6:0] KEY_SCROLL = 7'h46;

  // Lock flag and LED bit positions.
  localparam logic [2:0] LOCK_SCROLL = 3'b001;
  localparam logic [2:0] LOCK_NUM    = 3'b010;
  localparam logic [2:0] LOCK_CAPS   = 3'b100;

  // Terminal switch requests.
  localparam logic [1:0] SW_NONE   = 2'd0;
  localparam logic [1:0] SW_NEXT   = 2'd1;
  localparam logic [1:0] SW_KERNEL = 2'd2;

  localparam logic [7:0] CHAR_NONE = 8'hFF;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } fifo_op_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [7:0]         rd_data;
    logic [FIFO_CW-1:0] count_nxt;
  } fifo_stat_t;

  typedef struct packed {
    logic [7:0] key_char;
    logic       key_valid;
    logic [2:0] led_bits;
    logic       led_update;
    logic [1:0] switch_request;
  } key_res_t;

  // Key map: [31:24] normal, [23:16] shifted, [15:8] caps, [7:0] numpad.
  function automatic logic [31:0] key_map(input logic [6:0] code);
    logic [31:0] w;
    case (code)
      7'h02: w = 32'h31210000;  7'h03: w = 32'h32400000;
      7'h04: w = 32'h33230000;  7'h05: w = 32'h34240000;
      7'h06: w = 32'h35250000;  7'h07: w = 32'h365e0000;
      7'h08: w = 32'h37260000;  7'h09: w = 32'h382a0000;
      7'h0A: w = 32'h39280000;  7'h0B: w = 32'h30290000;
      7'h0C: w = 32'h2d5f0000;  7'h0D: w = 32'h3d2b0000;
      7'h10: w = 32'h71515100;  7'h11: w = 32'h77575700;
      7'h12: w = 32'h65454500;  7'h13: w = 32'h72525200;
      7'h14: w = 32'h74545400;  7'h15: w = 32'h79595900;
      7'h16: w = 32'h75555500;  7'h17: w = 32'h69494900;
      7'h18: w = 32'h6f4f4f00;  7'h19: w = 32'h70505000;
      7'h1A: w = 32'h5b7b0000;  7'h1B: w = 32'h5d7d0000;
      7'h1C: w = 32'h0d0d0d0d;  7'h1E: w = 32'h61414100;
      7'h1F: w = 32'h73535300;  7'h20: w = 32'h64444400;
      7'h21: w = 32'h66464600;  7'h22: w = 32'h67474700;
      7'h23: w = 32'h68484800;  7'h24: w = 32'h6a4a4a00;
      7'h25: w = 32'h6b4b4b00;  7'h26: w = 32'h6c4c4c00;
      7'h27: w = 32'h3b3a0000;  7'h28: w = 32'h27220000;
      7'h29: w = 32'h607e0000;  7'h2B: w = 32'h5c7c0000;
      7'h2C: w = 32'h7a5a5a00;  7'h2D: w = 32'h78585800;
      7'h2E: w = 32'h63434300;  7'h2F: w = 32'h76565600;
      7'h30: w = 32'h62424200;  7'h31: w = 32'h6e4e4e00;
      7'h32: w = 32'h6d4d4d00;  7'h33: w = 32'h2c3c0000;
      7'h34: w = 32'h2e3e0000;  7'h35: w = 32'h2f3f0000;
      7'h39: w = 32'h20202020;  7'h47: w = 32'h00000037;
      7'h48: w = 32'h00000038;  7'h49: w = 32'h00000039;
      7'h4A: w = 32'h2d2d2d2d;  7'h4B: w = 32'h00000034;
      7'h4C: w = 32'h00000035;  7'h4D: w = 32'h00000036;
      7'h4E: w = 32'h2b2b2b2b;  7'h4F: w = 32'h00000031;
      7'h50: w = 32'h00000032;  7'h51: w = 32'h00000033;
      7'h52: w = 32'h00000030;  7'h53: w = 32'h0000002e;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

  // Any shift wins; otherwise caps and then num lock may override the normal byte.
  function automatic logic [7:0] translate(input logic [6:0] code, input logic [1:0] shift,
                                           input logic [2:0] locks);
    logic [31:0] w;
    logic [7:0]  ch;
    w  = key_map(code);
    ch = w[31:24];
    if (shift != 2'b00) begin
      ch = w[23:16];
    end else begin
      if ((w[15:8] != 8'h00) && ((locks & LOCK_CAPS) != 3'b000)) begin
        ch = w[15:8];
      end
      if ((w[7:0] != 8'h00) && ((locks & LOCK_NUM) != 3'b000)) begin
        ch = w[7:0];
      end
    end
    return ch;
  endfunction

endpackage

@@ design/keyboard_scancode_translator_fifo_core.sv @@
`timescale 1ns / 1ps

// Set-1 keyboard scan code translator with a 16-byte key FIFO.
// Input channel: in_tdata carries a scan code, in_tuser says what the request
// is (0 = a scan code arrives, 1 = read one key from the FIFO). Every request
// produces exactly one result on the output channel, in order.
// A scan code press updates alt, shift and lock flags, or is translated to a
// byte and queued (dropped when the FIFO is full). Alt with a shift key asks
// for a terminal switch and empties the FIFO. A read returns the oldest byte,
// or 0xFF with key_valid low when the FIFO is empty.
// A request is captured in an input register, then decoded, translated and
// applied to the state in a single pass into the result register, which loads
// whenever it is empty or its result is being taken. Throughput is one request
// per cycle while the receiver keeps taking results, set by the lookup and FIFO
// update path between the two registers. If the receiver stalls, the result
// register holds; the input register can still take one more request, after
// which in_tready drops until the result is taken. Reset clears all flags and
// the FIFO pointers; the FIFO contents themselves are not cleared, since the
// count makes stale entries unreachable.
module keyboard_scancode_translator_fifo_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_code
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] key_char, [8] key_valid, [11:9] led_bits, [12] led_update,
  // [14:13] switch_request, [19:15] keys_waiting, [23:20] zero
  output logic [23:0] out_tdata
);

  logic       s1_valid_r;
  logic       s1_action_r;
  logic [7:0] s1_code_r;
  logic       out_valid_r;
  logic [23:0] out_data_r, out_data_nxt;

  logic out_advance;
  logic fire;

  ksft_pkg::fifo_op_t   fifo_op;
  ksft_pkg::fifo_stat_t fifo_stat;
  ksft_pkg::key_res_t   res;

  // The result register moves whenever it is empty or being taken; the input
  // register hands its request on in the same cycle, so the pipe never bubbles.
  assign out_advance = !out_valid_r || out_tready;
  assign fire        = s1_valid_r && out_advance;
  assign in_tready   = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_code_r   <= in_tdata;
    end
  end

  ksft_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .action    (s1_action_r),
    .key_code  (s1_code_r),
    .stat      (fifo_stat),
    .op        (fifo_op),
    .res       (res)
  );

  ksft_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (fifo_op),
    .stat  (fifo_stat)
  );

  assign out_data_nxt = {4'b0000, 5'(fifo_stat.count_nxt), res.switch_request,
                         res.led_update, res.led_bits, res.key_valid, res.key_char};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The queue never reports more bytes than it can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:15] <= 5'(ksft_pkg::FIFO_DEPTH)))
    else $error("keys_waiting exceeds FIFO depth");

  // A terminal switch always leaves the FIFO empty.
  a_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[14:13] != ksft_pkg::SW_NONE)) |-> (out_tdata[19:15] == 5'd0))
    else $error("switch request left keys in the FIFO");

  // A successful read neither switches terminals nor touches the LEDs.
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tdata[14:13] == ksft_pkg::SW_NONE && !out_tdata[12]))
    else $error("read result carries a lock or switch event");

  // A request that moves into the result stage always leaves a valid result.
  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

endmodule

@@ design/ksft_fifo.sv @@
`timescale 1ns / 1ps

module ksft_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ksft_pkg::fifo_op_t    op,
  output ksft_pkg::fifo_stat_t  stat
);

  localparam int AW = ksft_pkg::FIFO_AW;
  localparam int CW = ksft_pkg::FIFO_CW;
  localparam int DEPTH = ksft_pkg::FIFO_DEPTH;

  logic [7:0]    store_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointers wrap explicitly so any depth works, not only powers of two.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (op.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (op.push) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r + CW'(1);
    end else if (op.pop) begin
      tail_nxt  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      store_r[head_r] <= op.wdata;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.rd_data   = store_r[tail_r];
  assign stat.count_nxt = count_nxt;

endmodule

@@ design/ksft_decode.sv @@
`timescale 1ns / 1ps

module ksft_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  action,
  input  logic [7:0]            key_code,
  input  ksft_pkg::fifo_stat_t  stat,
  output ksft_pkg::fifo_op_t    op,
  output ksft_pkg::key_res_t    res
);

  logic       alt_r, alt_nxt;
  logic [1:0] shift_r, shift_nxt;
  logic [2:0] lock_r, lock_nxt;
  logic [2:0] down_r, down_nxt;
  ksft_pkg::fifo_op_t op_raw;

  function automatic logic [2:0] lock_sel(input logic [6:0] code);
    logic [2:0] sel;
    case (code)
      ksft_pkg::KEY_CAPS:   sel = ksft_pkg::LOCK_CAPS;
      ksft_pkg::KEY_NUM:    sel = ksft_pkg::LOCK_NUM;
      ksft_pkg::KEY_SCROLL: sel = ksft_pkg::LOCK_SCROLL;
      default:              sel = 3'b000;
    endcase
    return sel;
  endfunction

  always_comb begin
    alt_nxt   = alt_r;
    shift_nxt = shift_r;
    lock_nxt  = lock_r;
    down_nxt  = down_r;
    op_raw    = '0;
    res       = '0;
    res.key_char       = ksft_pkg::CHAR_NONE;
    res.switch_request = ksft_pkg::SW_NONE;

    if (action) begin
      if (!stat.empty) begin
        op_raw.pop    = 1'b1;
        res.key_char  = stat.rd_data;
        res.key_valid = 1'b1;
      end
    end else if (!key_code[7]) begin
      case (key_code[6:0])
        ksft_pkg::KEY_LSHIFT: begin
          if (alt_r) begin
            res.switch_request = ksft_pkg::SW_NEXT;
            op_raw.clear       = 1'b1;
          end else begin
            shift_nxt[0] = 1'b1;
          end
        end
        ksft_pkg::KEY_RSHIFT: begin
          if (alt_r) begin
            res.switch_request = ksft_pkg::SW_KERNEL;
            op_raw.clear       = 1'b1;
          end else begin
            shift_nxt[1] = 1'b1;
          end
        end
        ksft_pkg::KEY_ALT: alt_nxt = 1'b1;
        ksft_pkg::KEY_CAPS, ksft_pkg::KEY_NUM, ksft_pkg::KEY_SCROLL: begin
          // Toggle once per press; auto-repeat while held is ignored.
          if ((down_r & lock_sel(key_code[6:0])) == 3'b000) begin
            lock_nxt       = lock_r ^ lock_sel(key_code[6:0]);
            down_nxt       = down_r | lock_sel(key_code[6:0]);
            res.led_update = 1'b1;
          end
        end
        default: begin
          if (!stat.full) begin
            op_raw.push  = 1'b1;
            op_raw.wdata = ksft_pkg::translate(key_code[6:0], shift_r, lock_r);
          end
        end
      endcase
    end else begin
      case (key_code[6:0])
        ksft_pkg::KEY_ALT:    alt_nxt = 1'b0;
        ksft_pkg::KEY_LSHIFT: shift_nxt[0] = 1'b0;
        ksft_pkg::KEY_RSHIFT: shift_nxt[1] = 1'b0;
        ksft_pkg::KEY_CAPS, ksft_pkg::KEY_NUM, ksft_pkg::KEY_SCROLL: begin
          down_nxt = down_r & ~lock_sel(key_code[6:0]);
        end
        default: ;
      endcase
    end
    res.led_bits = lock_nxt;
  end

  assign op.push  = op_raw.push & fire;
  assign op.pop   = op_raw.pop & fire;
  assign op.clear = op_raw.clear & fire;
  assign op.wdata = op_raw.wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r   <= 1'b0;
      shift_r <= 2'b00;
      lock_r  <= 3'b000;
      down_r  <= 3'b000;
    end else if (fire) begin
      alt_r   <= alt_nxt;
      shift_r <= shift_nxt;
      lock_r  <= lock_nxt;
      down_r  <= down_nxt;
    end
  end

endmodule

@@ test/keyboard_scancode_translator_fifo_core_tb.sv @@
`timescale 1ns / 1ps

module keyboard_scancode_translator_fifo_core_tb;

  // What a request asks of the block, carried on in_tuser.
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Bit positions of the two shift keys in the local shift flags.
  localparam logic [1:0] SHIFT_LEFT  = 2'b01;
  localparam logic [1:0] SHIFT_RIGHT = 2'b10;

  // Cycles in which neither channel moves anything before the run is declared hung.
  // The slowest correct request needs only the sender's idle gap, the receiver's stall
  // and its pass through the block's input and result registers, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;
  localparam int TARGET_REQUESTS = 1850;

  // Key map word per make code: [31:24] normal, [23:16] shifted, [15:8] caps,
  // [7:0] numpad. Codes past 0x53 have no mapping and translate to 0x00.
  localparam logic [31:0] KEY_WORDS [128] = '{
    32'h00000000, 32'h00000000, 32'h31210000, 32'h32400000,
    32'h33230000, 32'h34240000, 32'h35250000, 32'h365e0000,
    32'h37260000, 32'h382a0000, 32'h39280000, 32'h30290000,
    32'h2d5f0000, 32'h3d2b0000, 32'h00000000, 32'h00000000,
    32'h71515100, 32'h77575700, 32'h65454500, 32'h72525200,
    32'h74545400, 32'h79595900, 32'h75555500, 32'h69494900,
    32'h6f4f4f00, 32'h70505000, 32'h5b7b0000, 32'h5d7d0000,
    32'h0d0d0d0d, 32'h00000000, 32'h61414100, 32'h73535300,
    32'h64444400, 32'h66464600, 32'h67474700, 32'h68484800,
    32'h6a4a4a00, 32'h6b4b4b00, 32'h6c4c4c00, 32'h3b3a0000,
    32'h27220000, 32'h607e0000, 32'h00000000, 32'h5c7c0000,
    32'h7a5a5a00, 32'h78585800, 32'h63434300, 32'h76565600,
    32'h62424200, 32'h6e4e4e00, 32'h6d4d4d00, 32'h2c3c0000,
    32'h2e3e0000, 32'h2f3f0000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h20202020, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000037,
    32'h00000038, 32'h00000039, 32'h2d2d2d2d, 32'h00000034,
    32'h00000035, 32'h00000036, 32'h2b2b2b2b, 32'h00000031,
    32'h00000032, 32'h00000033, 32'h00000030, 32'h0000002e,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  // One result as it appears on out_tdata, lowest field declared last.
  typedef struct packed {
    logic [3:0] spare;
    logic [4:0] keys_waiting;
    logic [1:0] switch_request;
    logic       led_update;
    logic [2:0] led_bits;
    logic       key_valid;
    logic [7:0] key_char;
  } key_result_t;

  // One request waiting to be sent, with the idle cycles that precede it. A request
  // marked hold_for_drain is not offered until every expected result has come back.
  typedef struct packed {
    logic       action;
    logic [7:0] code;
    logic [4:0] gap;
    logic       hold_for_drain;
  } key_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  keyboard_scancode_translator_fifo_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the translator state, advanced once for every accepted request.
  logic       alt_down = 1'b0;
  logic [1:0] shift_down = 2'b00;
  logic [2:0] lock_on = 3'b000;
  logic [2:0] lock_held = 3'b000;
  logic [7:0] key_fifo[$];

  key_request_t request_queue[$];
  key_result_t  expected_results[$];

  int  total_requests = 0;
  int  requests_taken = 0;
  int  effective_requests = 0;
  int  error_count = 0;
  int  idle_cycles = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  gen_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // A lock key toggles its LED only on the first press; auto-repeat while the key is
  // still held is ignored until the release clears the held flag.
  function automatic logic toggle_lock(input logic [2:0] mask);
    if ((lock_held & mask) != 3'b000) begin
      return 1'b0;
    end
    lock_on   = lock_on ^ mask;
    lock_held = lock_held | mask;
    return 1'b1;
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic key_result_t apply_request(input logic action, input logic [7:0] code);
    key_result_t res;
    logic [31:0] word;
    logic [7:0]  ch;
    res = '0;
    res.key_char = ksft_pkg::CHAR_NONE;
    res.switch_request = ksft_pkg::SW_NONE;
    if (action == ACT_READ) begin
      if (key_fifo.size() != 0) begin
        res.key_char  = key_fifo.pop_front();
        res.key_valid = 1'b1;
      end
    end else if (!code[7]) begin
      case (code[6:0])
        ksft_pkg::KEY_LSHIFT: begin
          // Alt plus a shift is a terminal switch and never latches the shift.
          if (alt_down) begin
            res.switch_request = ksft_pkg::SW_NEXT;
            key_fifo.delete();
          end else begin
            shift_down = shift_down | SHIFT_LEFT;
          end
        end
        ksft_pkg::KEY_RSHIFT: begin
          if (alt_down) begin
            res.switch_request = ksft_pkg::SW_KERNEL;
            key_fifo.delete();
          end else begin
            shift_down = shift_down | SHIFT_RIGHT;
          end
        end
        ksft_pkg::KEY_ALT: alt_down = 1'b1;
        ksft_pkg::KEY_CAPS: res.led_update = toggle_lock(ksft_pkg::LOCK_CAPS);
        ksft_pkg::KEY_NUM: res.led_update = toggle_lock(ksft_pkg::LOCK_NUM);
        ksft_pkg::KEY_SCROLL: res.led_update = toggle_lock(ksft_pkg::LOCK_SCROLL);
        default: begin
          if (key_fifo.size() < ksft_pkg::FIFO_DEPTH) begin
            word = KEY_WORDS[code[6:0]];
            if (shift_down != 2'b00) begin
              ch = word[23:16];
            end else begin
              // Caps lock first, then num lock may override, each only where the
              // key has a byte of that kind.
              ch = word[31:24];
              if (word[15:8] != 8'h00 && (lock_on & ksft_pkg::LOCK_CAPS) != 3'b000) begin
                ch = word[15:8];
              end
              if (word[7:0] != 8'h00 && (lock_on & ksft_pkg::LOCK_NUM) != 3'b000) begin
                ch = word[7:0];
              end
            end
            key_fifo.push_back(ch);
          end
        end
      endcase
    end else begin
      // Releases only matter for modifiers and lock keys.
      case (code[6:0])
        ksft_pkg::KEY_ALT: alt_down = 1'b0;
        ksft_pkg::KEY_LSHIFT: shift_down = shift_down & ~SHIFT_LEFT;
        ksft_pkg::KEY_RSHIFT: shift_down = shift_down & ~SHIFT_RIGHT;
        ksft_pkg::KEY_CAPS: lock_held = lock_held & ~ksft_pkg::LOCK_CAPS;
        ksft_pkg::KEY_NUM: lock_held = lock_held & ~ksft_pkg::LOCK_NUM;
        ksft_pkg::KEY_SCROLL: lock_held = lock_held & ~ksft_pkg::LOCK_SCROLL;
        default: ;
      endcase
    end
    res.led_bits = lock_on;
    res.keys_waiting = 5'(key_fifo.size());
    return res;
  endfunction

  function automatic bit is_modifier(input logic [7:0] code);
    case (code[6:0])
      ksft_pkg::KEY_LSHIFT, ksft_pkg::KEY_RSHIFT, ksft_pkg::KEY_ALT,
      ksft_pkg::KEY_CAPS, ksft_pkg::KEY_NUM, ksft_pkg::KEY_SCROLL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // A press of a key that goes through the key map: numpad keys, the usual
  // typing block, or anything in the 7-bit range, never a modifier or lock.
  function automatic logic [7:0] ordinary_key();
    logic [7:0] code;
    do begin
      case ($urandom_range(0, 3))
        0: code = 8'($urandom_range(8'h47, 8'h53));
        1: code = 8'($urandom_range(0, 127));
        default: code = 8'($urandom_range(8'h02, 8'h39));
      endcase
    end while (is_modifier(code));
    return code;
  endfunction

  function automatic logic [7:0] random_lock_key();
    case ($urandom_range(0, 2))
      0: return {1'b0, ksft_pkg::KEY_CAPS};
      1: return {1'b0, ksft_pkg::KEY_NUM};
      default: return {1'b0, ksft_pkg::KEY_SCROLL};
    endcase
  endfunction

  // Queues one request; every request counts toward the size of the run.
  task automatic add_request(input logic action, input logic [7:0] code,
                             input logic hold = 1'b0);
    key_request_t req;
    req.action = action;
    req.code = code;
    req.gap = gen_quiet ? 5'd0 : 5'($urandom_range(0, 18));
    req.hold_for_drain = hold;
    request_queue.push_back(req);
    effective_requests++;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Stimulus: a short directed walk through the special cases, then random
  // sequences shaped like real typing with some noise mixed in.
  initial begin
    int unsigned kind;
    int unsigned n;
    logic [7:0]  key;
    logic [7:0]  shift_key;

    // Reading an empty FIFO, plain, shifted, caps and numpad translation.
    add_request(ACT_READ, 8'h00);
    add_request(ACT_SCAN, 8'h1E);
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_LSHIFT});
    add_request(ACT_SCAN, 8'h1E);
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_LSHIFT});
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_CAPS});
    // Second caps press while still held must not toggle again.
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_CAPS});
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_CAPS});
    add_request(ACT_SCAN, 8'h1E);
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_NUM});
    add_request(ACT_SCAN, 8'h47);
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_NUM});
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_SCROLL});
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_SCROLL});
    // Unmapped keys queue a zero byte; releases of other keys do nothing.
    add_request(ACT_SCAN, 8'h7F);
    add_request(ACT_SCAN, 8'h00);
    add_request(ACT_SCAN, 8'hFF);
    add_request(ACT_SCAN, 8'h80);
    add_request(ACT_READ, 8'hFF);
    // Alt with either shift asks for a terminal switch and flushes the FIFO.
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_ALT});
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_LSHIFT});
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_RSHIFT});
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_ALT});
    add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_RSHIFT});
    add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_RSHIFT});

    // The first random request waits until the directed part has fully drained.
    add_request(ACT_READ, 8'($urandom_range(0, 255)), 1'b1);

    while (effective_requests < TARGET_REQUESTS) begin
      // Some sequences run with no idle cycles at all on the sending side.
      gen_quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          key = ordinary_key();
          add_request(ACT_SCAN, key);
          if ($urandom_range(0, 2) == 0) begin
            add_request(ACT_SCAN, key | 8'h80);
          end
        end
      end else if (kind < 50) begin
        n = $urandom_range(1, 10);
        repeat (n) add_request(ACT_READ, 8'($urandom_range(0, 255)),
                               $urandom_range(0, 149) == 0);
      end else if (kind < 62) begin
        shift_key = $urandom_range(0, 1) ? {1'b0, ksft_pkg::KEY_LSHIFT} :
                                           {1'b0, ksft_pkg::KEY_RSHIFT};
        add_request(ACT_SCAN, shift_key);
        n = $urandom_range(1, 5);
        repeat (n) add_request(ACT_SCAN, ordinary_key());
        add_request(ACT_SCAN, shift_key | 8'h80);
      end else if (kind < 72) begin
        key = random_lock_key();
        n = $urandom_range(1, 3);
        repeat (n) add_request(ACT_SCAN, key);
        add_request(ACT_SCAN, key | 8'h80);
        n = $urandom_range(1, 4);
        repeat (n) add_request(ACT_SCAN, 8'($urandom_range(8'h47, 8'h53)));
      end else if (kind < 80) begin
        add_request(ACT_SCAN, {1'b0, ksft_pkg::KEY_ALT});
        n = $urandom_range(0, 3);
        repeat (n) add_request(ACT_SCAN, ordinary_key());
        shift_key = $urandom_range(0, 1) ? {1'b0, ksft_pkg::KEY_LSHIFT} :
                                           {1'b0, ksft_pkg::KEY_RSHIFT};
        add_request(ACT_SCAN, shift_key);
        if ($urandom_range(0, 1) == 0) begin
          add_request(ACT_SCAN, shift_key | 8'h80);
        end
        add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_ALT});
      end else if (kind < 88) begin
        // Overfill the FIFO so that some presses are dropped, then drain part of it.
        n = $urandom_range(17, 20);
        repeat (n) add_request(ACT_SCAN, ordinary_key());
        n = $urandom_range(0, 20);
        repeat (n) add_request(ACT_READ, 8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        // Let go of every modifier so that noise does not leave one stuck.
        add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_ALT});
        add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_LSHIFT});
        add_request(ACT_SCAN, {1'b1, ksft_pkg::KEY_RSHIFT});
      end
    end
    total_requests = request_queue.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (requests_taken < total_requests || expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Give any stray result from the block time to show up.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Sender: a new request is offered at the falling edge after the previous one was
  // taken, once its idle gap has run out.
  always @(negedge clk) begin
    key_request_t req;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (request_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (tx_wait < request_queue[0].gap ||
                   (request_queue[0].hold_for_drain && expected_results.size() != 0)) begin
        in_tvalid <= 1'b0;
        if (tx_wait < request_queue[0].gap) begin
          tx_wait++;
        end
      end else begin
        req = request_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= req.action;
        in_tdata <= req.code;
        tx_wait = 0;
      end
    end
  end

  // Receiver: after each result it stalls for a random number of cycles, with
  // occasional stretches where it never stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) begin
          rx_quiet = !rx_quiet;
        end
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 18);
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Both handshakes are sampled here. A result leaves the block only after its request
  // has passed the input and result registers, so checking before predicting keeps the order right.
  always @(posedge clk) begin
    key_result_t seen;
    key_result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = key_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got 0x%06h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("key_char", want.key_char, seen.key_char);
          check_field("key_valid", want.key_valid, seen.key_valid);
          check_field("led_bits", want.led_bits, seen.led_bits);
          check_field("led_update", want.led_update, seen.led_update);
          check_field("switch_request", want.switch_request, seen.switch_request);
          check_field("keys_waiting", want.keys_waiting, seen.keys_waiting);
          check_field("spare bits", want.spare, seen.spare);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(in_tuser, in_tdata));
        requests_taken++;
      end
      // Watchdog: a run with no traffic on either channel for this long is stuck.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

endmodule
